FILE: design/skt_pkg.sv
// sorted key table package: operation, status, cell command and state types
// no dependencies; imported by skt_cell and sorted_key_table_unit
package skt_pkg;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_REMOVE = 3'd1,
      OP_FIND   = 3'd2,
      OP_GET    = 3'd3,
      OP_DELETE = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_RANGE     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_REMOVE
   } cell_cmd_type;

   typedef struct packed {
      logic eq;
      logic go_left;
   } cell_flags_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_SEARCH,
      S_EXEC
   } state_type;

   localparam logic CSR_ORDER_DESCENDING = 1'b0;
   localparam logic CSR_ALLOW_DUPLICATES = 1'b1;

endpackage

FILE: design/sorted_key_table_unit.sv
// sorted key table top level: control sequencer, bisection and chain of cells
// depends on skt_pkg and skt_cell
//
// Usage: drive req_op, req_key, req_value and req_entry_index with start high
// while busy is low; the transaction is taken at that edge. Exactly one result
// follows, shown for one cycle with rsp_valid high; the receiver cannot stall
// it and it is never held. For add, remove and find, every cell first compares
// its key with the request key, then the bisection walks the registered compare
// flags one probe per cycle; get, delete and undefined ops skip both steps. The
// exec state then shifts the cell chain (insert or remove) and registers the
// result. A new transaction may start in the cycle the result is shown. csr
// writes take effect at once; the user must make them only while idle, the
// block does not enforce it. Reset empties the table (count zero) and clears
// both csr registers; cell contents are not cleared and are never read before
// written.
module sorted_key_table_unit #(
   parameter int DEPTH       = 64,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32,
   localparam int IDX_W      = $clog2(DEPTH),
   localparam int CNT_W      = $clog2(DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [2:0]             req_op,
   input  logic [KEY_WIDTH-1:0]   req_key,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic [IDX_W-1:0]       req_entry_index,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_status,
   output logic [KEY_WIDTH-1:0]   rsp_key_out,
   output logic [VALUE_WIDTH-1:0] rsp_value_out,
   output logic [IDX_W-1:0]       rsp_position,
   output logic [CNT_W-1:0]       rsp_count,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic                   csr_wdata
);
   import skt_pkg::*;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   state_type state_ff, state_in;

   logic                   order_desc_ff, allow_dup_ff;
   logic [2:0]             op_ff, op_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       low_ff, low_in;
   logic [CNT_W-1:0]       high_ff, high_in;
   logic [CNT_W-1:0]       at_ff, at_in;
   logic                   hit_ff, hit_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             status_ff, status_in;
   logic [KEY_WIDTH-1:0]   kout_ff, kout_in;
   logic [VALUE_WIDTH-1:0] vout_ff, vout_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;

   cell_cmd_type           cmd;
   logic [CNT_W:0]         mid_sum;
   logic [CNT_W-1:0]       mid;
   cell_flags_type         probe;
   logic [IDX_W-1:0]       rd_idx;

   logic [KEY_WIDTH-1:0]   cell_key   [DEPTH];
   logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
   cell_flags_type         cell_flags [DEPTH];

   // chain of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_WIDTH-1:0]   lk, rk;
      logic [VALUE_WIDTH-1:0] lv, rv;
      if (i == 0) begin : g_first
         assign lk = cell_key[i];
         assign lv = cell_value[i];
      end else begin : g_left
         assign lk = cell_key[i-1];
         assign lv = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign rk = cell_key[i];
         assign rv = cell_value[i];
      end else begin : g_right
         assign rk = cell_key[i+1];
         assign rv = cell_value[i+1];
      end
      skt_cell #(
         .KEY_WIDTH   (KEY_WIDTH),
         .VALUE_WIDTH (VALUE_WIDTH),
         .CNT_W       (CNT_W),
         .IDX         (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .at          (at_ff),
         .descending  (order_desc_ff),
         .search_key  (key_ff),
         .new_value   (value_ff),
         .left_key    (lk),
         .left_value  (lv),
         .right_key   (rk),
         .right_value (rv),
         .key         (cell_key[i]),
         .value       (cell_value[i]),
         .flags       (cell_flags[i])
      );
   end

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         order_desc_ff <= 1'b0;
         allow_dup_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ORDER_DESCENDING: order_desc_ff <= csr_wdata;
            CSR_ALLOW_DUPLICATES: allow_dup_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // bisection probe: mid = floor((low + high - 1) / 2) with high exclusive here
   assign mid_sum = {1'b0, low_ff} + {1'b0, high_ff} - {{CNT_W{1'b0}}, 1'b1};
   assign mid     = mid_sum[CNT_W:1];
   assign probe   = cell_flags[mid[IDX_W-1:0]];
   assign rd_idx  = at_ff[IDX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      at_in        = at_ff;
      hit_in       = hit_ff;
      rsp_valid_in = 1'b0;
      status_in    = ST_OK;
      kout_in      = '0;
      vout_in      = '0;
      pos_in       = '0;
      cmd          = CMD_HOLD;
      busy         = (state_ff != S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_op;
               key_in   = req_key;
               value_in = req_value;
               at_in    = CNT_W'(req_entry_index);
               hit_in   = (CNT_W'(req_entry_index) < count_ff);
               if (req_op == OP_ADD || req_op == OP_REMOVE || req_op == OP_FIND) begin
                  state_in = S_COMPARE;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_COMPARE: begin
            low_in   = '0;
            high_in  = count_ff;
            state_in = S_SEARCH;
         end
         S_SEARCH: begin
            if (low_ff < high_ff) begin
               if (probe.eq) begin
                  hit_in   = 1'b1;
                  at_in    = mid;
                  state_in = S_EXEC;
               end else if (probe.go_left) begin
                  high_in = mid;
               end else begin
                  low_in = mid + 1'b1;
               end
            end else begin
               hit_in   = 1'b0;
               at_in    = low_ff;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            case (op_ff) inside
               OP_ADD: begin
                  if (hit_ff && !allow_dup_ff) begin
                     status_in = ST_DUPLICATE;
                  end else if (count_ff == DEPTH_CNT) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd      = CMD_INSERT;
                     pos_in   = at_ff[IDX_W-1:0];
                     count_in = count_ff + 1'b1;
                  end
               end
               OP_REMOVE, OP_FIND: begin
                  if (hit_ff) begin
                     vout_in = cell_value[rd_idx];
                     pos_in  = rd_idx;
                     if (op_ff == OP_REMOVE) begin
                        cmd      = CMD_REMOVE;
                        count_in = count_ff - 1'b1;
                     end
                  end else begin
                     status_in = ST_NOT_FOUND;
                  end
               end
               OP_GET, OP_DELETE: begin
                  if (hit_ff) begin
                     kout_in = cell_key[rd_idx];
                     vout_in = cell_value[rd_idx];
                     pos_in  = rd_idx;
                     if (op_ff == OP_DELETE) begin
                        cmd      = CMD_REMOVE;
                        count_in = count_ff - 1'b1;
                     end
                  end else begin
                     status_in = ST_RANGE;
                  end
               end
               default: ;
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      value_ff  <= value_in;
      low_ff    <= low_in;
      high_ff   <= high_in;
      at_ff     <= at_in;
      hit_ff    <= hit_in;
      status_ff <= status_in;
      kout_ff   <= kout_in;
      vout_ff   <= vout_in;
      pos_ff    <= pos_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_key_out   = kout_ff;
   assign rsp_value_out = vout_ff;
   assign rsp_position  = pos_ff;
   assign rsp_count     = count_ff;

endmodule

FILE: design/skt_cell.sv
// one table cell: holds a key/value pair, shifts with its neighbors, compares
// its key against the search key; depends on skt_pkg
module skt_cell #(
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32,
   parameter int CNT_W       = 7,
   parameter int IDX         = 0
) (
   input  logic                   clock,
   input  skt_pkg::cell_cmd_type  cmd,
   input  logic [CNT_W-1:0]       at,
   input  logic                   descending,
   input  logic [KEY_WIDTH-1:0]   search_key,
   input  logic [VALUE_WIDTH-1:0] new_value,
   input  logic [KEY_WIDTH-1:0]   left_key,
   input  logic [VALUE_WIDTH-1:0] left_value,
   input  logic [KEY_WIDTH-1:0]   right_key,
   input  logic [VALUE_WIDTH-1:0] right_value,
   output logic [KEY_WIDTH-1:0]   key,
   output logic [VALUE_WIDTH-1:0] value,
   output skt_pkg::cell_flags_type flags
);
   import skt_pkg::*;

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   cell_flags_type         flags_ff, flags_in;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      case (cmd)
         CMD_INSERT: begin
            if (at == MY_IDX) begin
               key_in   = search_key;
               value_in = new_value;
            end else if (at < MY_IDX) begin
               key_in   = left_key;
               value_in = left_value;
            end
         end
         CMD_REMOVE: begin
            if (at <= MY_IDX) begin
               key_in   = right_key;
               value_in = right_value;
            end
         end
         default: ;
      endcase
      flags_in.eq      = (search_key == key_ff);
      flags_in.go_left = descending ? (search_key > key_ff) : (search_key < key_ff);
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      flags_ff <= flags_in;
   end

   assign key   = key_ff;
   assign value = value_ff;
   assign flags = flags_ff;

endmodule

FILE: tb/sv/sorted_key_table_unit_tb.sv
// self-checking testbench for sorted_key_table_unit: directed and random table operations,
// a clocked driver and monitor, and a built-in table predictor checking every result
// depends on skt_pkg and sorted_key_table_unit
module sorted_key_table_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import skt_pkg::*;

   localparam int DEPTH         = 64;
   localparam int IDX_W         = 6;
   localparam int CNT_W         = 7;
   localparam int SETTLE_CYCLES = 14;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 20;

   typedef struct packed {
      logic [2:0]       status;
      logic [31:0]      key_out;
      logic [31:0]      value_out;
      logic [IDX_W-1:0] position;
      logic [CNT_W-1:0] count;
   } reply_type;

   typedef struct {
      bit               is_csr;
      logic             csr_idx;
      logic             csr_val;
      logic [2:0]       op;
      logic [31:0]      key;
      logic [31:0]      value;
      logic [IDX_W-1:0] entry_index;
      int unsigned      gap;
   } table_op_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [2:0]       req_op = '0;
   logic [31:0]      req_key = '0;
   logic [31:0]      req_value = '0;
   logic [IDX_W-1:0] req_entry_index = '0;
   logic             rsp_valid;
   logic [2:0]       rsp_status;
   logic [31:0]      rsp_key_out;
   logic [31:0]      rsp_value_out;
   logic [IDX_W-1:0] rsp_position;
   logic [CNT_W-1:0] rsp_count;
   logic             csr_we = 1'b0;
   logic             csr_index = 1'b0;
   logic             csr_wdata = 1'b0;

   sorted_key_table_unit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_key         (req_key),
      .req_value       (req_value),
      .req_entry_index (req_entry_index),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_key_out     (rsp_key_out),
      .rsp_value_out   (rsp_value_out),
      .rsp_position    (rsp_position),
      .rsp_count       (rsp_count),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // table predictor state
   logic [31:0] table_keys [DEPTH];
   logic [31:0] table_values [DEPTH];
   int          table_count = 0;
   logic        table_descending = 1'b0;
   logic        table_duplicates = 1'b0;

   table_op_type pending_ops [$];
   reply_type    expected_replies [$];

   logic        took = 1'b0;
   int          quiet_cycles = 0;
   int          stall_cycles = 0;
   int          wait_count = 0;
   int          errors = 0;
   int          transactions = 0;
   int          csr_writes = 0;
   int          status_seen [8];
   bit          burst_mode = 1'b0;
   logic [31:0] key_pool [64];

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void log_error(string msg);
      errors++;
      if (errors <= 10) begin
         $display("[%0t] ERROR: %s", $realtime, msg);
      end
   endfunction

   function automatic bit bisect_key(logic [31:0] k, output int at);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = table_count - 1;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (k == table_keys[mid]) begin
            at = mid;
            return 1'b1;
         end
         if (table_descending ? (k > table_keys[mid]) : (k < table_keys[mid])) begin
            hi = mid - 1;
         end else begin
            lo = mid + 1;
         end
      end
      at = lo;
      return 1'b0;
   endfunction

   function automatic void drop_entry(int pos);
      table_count--;
      for (int i = pos; i < table_count; i++) begin
         table_keys[i]   = table_keys[i + 1];
         table_values[i] = table_values[i + 1];
      end
   endfunction

   function automatic reply_type table_apply(logic [2:0] op, logic [31:0] k, logic [31:0] v,
                                             logic [IDX_W-1:0] ix);
      reply_type r;
      int        at;
      bit        found;
      r = '0;
      at = 0;
      case (op) inside
         OP_ADD: begin
            found = bisect_key(k, at);
            if (found && !table_duplicates) begin
               r.status = ST_DUPLICATE;
            end else if (table_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               for (int i = table_count; i > at; i--) begin
                  table_keys[i]   = table_keys[i - 1];
                  table_values[i] = table_values[i - 1];
               end
               table_keys[at]   = k;
               table_values[at] = v;
               table_count++;
               r.status   = ST_OK;
               r.position = at[IDX_W-1:0];
            end
         end
         OP_REMOVE, OP_FIND: begin
            if (bisect_key(k, at)) begin
               r.status    = ST_OK;
               r.value_out = table_values[at];
               r.position  = at[IDX_W-1:0];
               if (op == OP_REMOVE) begin
                  drop_entry(at);
               end
            end else begin
               r.status = ST_NOT_FOUND;
            end
         end
         OP_GET, OP_DELETE: begin
            if (int'(ix) < table_count) begin
               r.status    = ST_OK;
               r.key_out   = table_keys[ix];
               r.value_out = table_values[ix];
               r.position  = ix;
               if (op == OP_DELETE) begin
                  drop_entry(int'(ix));
               end
            end else begin
               r.status = ST_RANGE;
            end
         end
         default: r.status = ST_OK;
      endcase
      r.count = table_count[CNT_W-1:0];
      return r;
   endfunction

   // driver: inputs change at the falling edge
   always @(negedge clock) begin : drive_proc
      table_op_type head;
      logic         offer_n;
      logic         we_n;
      if (!reset) begin
         offer_n = start && !took;
         we_n = 1'b0;
         if (!offer_n && pending_ops.size() > 0) begin
            head = pending_ops[0];
            if (head.is_csr) begin
               if (expected_replies.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                  we_n = 1'b1;
                  csr_index <= head.csr_idx;
                  csr_wdata <= head.csr_val;
                  void'(pending_ops.pop_front());
               end
            end else if (wait_count < int'(head.gap)) begin
               wait_count++;
            end else begin
               offer_n = 1'b1;
               req_op <= head.op;
               req_key <= head.key;
               req_value <= head.value;
               req_entry_index <= head.entry_index;
               wait_count = 0;
               void'(pending_ops.pop_front());
            end
         end
         start <= offer_n;
         csr_we <= we_n;
      end
   end

   // monitor: results checked, transactions predicted at the rising edge
   always @(posedge clock) begin : watch_proc
      reply_type want;
      reply_type got;
      bit        moved;
      if (reset) begin
         took <= 1'b0;
         quiet_cycles <= 0;
         stall_cycles <= 0;
      end else begin
         moved = 1'b0;
         if (rsp_valid) begin
            moved = 1'b1;
            got = '{rsp_status, rsp_key_out, rsp_value_out, rsp_position, rsp_count};
            if (expected_replies.size() == 0) begin
               log_error($sformatf("result with nothing expected: status=%0d count=%0d",
                                   got.status, got.count));
            end else begin
               want = expected_replies.pop_front();
               status_seen[want.status]++;
               if (got.status !== want.status || got.key_out !== want.key_out ||
                   got.value_out !== want.value_out || got.position !== want.position ||
                   got.count !== want.count) begin
                  log_error($sformatf(
                     "exp st=%0d k=%h v=%h p=%0d c=%0d, got st=%0d k=%h v=%h p=%0d c=%0d",
                     want.status, want.key_out, want.value_out, want.position, want.count,
                     got.status, got.key_out, got.value_out, got.position, got.count));
               end
            end
         end
         if (start && !busy) begin
            moved = 1'b1;
            transactions++;
            expected_replies.push_back(table_apply(req_op, req_key, req_value, req_entry_index));
         end
         if (csr_we) begin
            moved = 1'b1;
            csr_writes++;
            case (csr_index)
               CSR_ORDER_DESCENDING: table_descending = csr_wdata;
               CSR_ALLOW_DUPLICATES: table_duplicates = csr_wdata;
               default: ;
            endcase
         end
         took <= start && !busy;
         quiet_cycles <= (expected_replies.size() == 0 && !start) ? quiet_cycles + 1 : 0;
         stall_cycles <= moved ? 0 : stall_cycles + 1;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 3) begin
         burst_mode = !burst_mode;
      end
      if (burst_mode || r < 45) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 15);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic void push_op(logic [2:0] op, logic [31:0] k, logic [31:0] v,
                                   logic [IDX_W-1:0] ix);
      table_op_type t;
      t = '{default: '0};
      t.op = op;
      t.key = k;
      t.value = v;
      t.entry_index = ix;
      t.gap = pick_gap();
      pending_ops.push_back(t);
   endfunction

   function automatic void push_csr(logic idx, logic val);
      table_op_type t;
      t = '{default: '0};
      t.is_csr = 1'b1;
      t.csr_idx = idx;
      t.csr_val = val;
      pending_ops.push_back(t);
   endfunction

   function automatic void set_mode(logic descending, logic duplicates);
      push_csr(CSR_ORDER_DESCENDING, descending);
      push_csr(CSR_ALLOW_DUPLICATES, duplicates);
   endfunction

   function automatic logic [31:0] pick_key(int pool_size);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return key_pool[$urandom_range(0, pool_size - 1)];
      end else if (r < 70) begin
         return 32'h0000_0000;
      end else if (r < 75) begin
         return 32'hffff_ffff;
      end
      return $urandom;
   endfunction

   function automatic void random_ops(int n, int add_pct, int pool_size);
      int unsigned r;
      logic [2:0]  op;
      logic [IDX_W-1:0] ix;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < add_pct) begin
            op = OP_ADD;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 25)      op = OP_REMOVE;
            else if (r < 55) op = OP_FIND;
            else if (r < 75) op = OP_GET;
            else if (r < 95) op = OP_DELETE;
            else             op = 3'($urandom_range(5, 7));
         end
         if ($urandom_range(0, 99) < 60) ix = IDX_W'($urandom_range(0, 15));
         else                            ix = IDX_W'($urandom_range(0, 63));
         push_op(op, pick_key(pool_size), $urandom, ix);
      end
   endfunction

   function automatic void empty_table();
      for (int i = 0; i < DEPTH; i++) begin
         push_op(OP_DELETE, $urandom, $urandom, '0);
      end
   endfunction

   initial begin : main_proc
      bit timed_out;
      timed_out = 1'b0;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hffff_ffff;
      for (int i = 2; i < 64; i++) begin
         key_pool[i] = $urandom;
      end

      // directed: empty table, undefined ops, extremes, duplicate, range checks
      set_mode(1'b0, 1'b0);
      push_op(OP_FIND, 32'h0000_0000, 32'h0, 6'd0);
      push_op(OP_GET, 32'h0, 32'h0, 6'd0);
      push_op(OP_DELETE, 32'h0, 32'h0, 6'd63);
      push_op(OP_REMOVE, 32'hffff_ffff, 32'h0, 6'd0);
      push_op(3'd5, 32'h1234_5678, 32'h9abc_def0, 6'd1);
      push_op(3'd6, 32'h0, 32'h0, 6'd0);
      push_op(3'd7, 32'hffff_ffff, 32'hffff_ffff, 6'd63);
      push_op(OP_ADD, 32'h0000_0000, 32'hffff_ffff, 6'd0);
      push_op(OP_ADD, 32'hffff_ffff, 32'h0000_0000, 6'd0);
      push_op(OP_ADD, 32'h8000_0000, 32'ha5a5_a5a5, 6'd0);
      push_op(OP_ADD, 32'h0000_0000, 32'h1111_1111, 6'd0);
      push_op(OP_ADD, 32'h7fff_ffff, 32'h5a5a_5a5a, 6'd0);
      push_op(OP_FIND, 32'hffff_ffff, 32'h0, 6'd0);
      push_op(OP_FIND, 32'h7fff_ffff, 32'h0, 6'd0);
      push_op(OP_GET, 32'h0, 32'h0, 6'd0);
      push_op(OP_GET, 32'h0, 32'h0, 6'd3);
      push_op(OP_GET, 32'h0, 32'h0, 6'd4);
      push_op(OP_GET, 32'h0, 32'h0, 6'd63);
      push_op(OP_REMOVE, 32'h8000_0000, 32'h0, 6'd0);
      push_op(OP_REMOVE, 32'h8000_0000, 32'h0, 6'd0);
      push_op(OP_DELETE, 32'h0, 32'h0, 6'd0);
      push_op(OP_DELETE, 32'h0, 32'h0, 6'd2);
      push_op(OP_DELETE, 32'h0, 32'h0, 6'd1);
      push_op(OP_FIND, 32'h5555_5555, 32'h0, 6'd0);

      // random phases over every register setting
      set_mode(1'b0, 1'b0);
      random_ops(220, 50, 40);
      empty_table();
      set_mode(1'b1, 1'b0);
      random_ops(200, 50, 40);
      empty_table();
      set_mode(1'b0, 1'b1);
      random_ops(200, 70, 12);
      set_mode(1'b1, 1'b1);
      random_ops(120, 40, 12);
      empty_table();
      set_mode(1'b1, 1'b1);
      random_ops(100, 75, 20);
      set_mode(1'b0, 1'b0);
      random_ops(100, 45, 64);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (!timed_out &&
             (pending_ops.size() > 0 || start || expected_replies.size() > 0)) begin
         @(posedge clock);
         if (stall_cycles >= STALL_LIMIT) begin
            timed_out = 1'b1;
         end
      end

      if (timed_out) begin
         $display("** sorted_key_table_unit: FAILED **");
      end else begin
         repeat (DRAIN_CYCLES) @(posedge clock);
         while (expected_replies.size() > 0) begin
            want_left: begin
               reply_type left;
               left = expected_replies.pop_front();
               log_error($sformatf("result never arrived: status=%0d count=%0d",
                                   left.status, left.count));
            end
         end
         $display("covered %0d transactions, %0d csr writes, both key orders, dups on and off",
                  transactions, csr_writes);
         $display("status ok %0d, dup %0d, full %0d, missing %0d, range %0d; errors %0d",
                  status_seen[ST_OK], status_seen[ST_DUPLICATE], status_seen[ST_FULL],
                  status_seen[ST_NOT_FOUND], status_seen[ST_RANGE], errors);
         if (errors == 0) begin
            $display("** sorted_key_table_unit: PASSED **");
         end else begin
            $display("** sorted_key_table_unit: FAILED **");
         end
      end
      $finish;
   end

endmodule

FILE: sim.f
design/skt_pkg.sv
design/skt_cell.sv
design/sorted_key_table_unit.sv
tb/sv/sorted_key_table_unit_tb.sv
